### rtl/core/assert_macros.svh
// Assertion macros shared by the mutex engine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check held off while the synchronous reset is asserted.
`define MTX_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that runs at every edge, reset included.
`define MTX_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MTX_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define MTX_ASSERT(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/rme_pkg.sv
// Shared types and constants for the recursive mutex engine.
// No dependencies.
package rme_pkg;

    localparam int TASK_ID_BITS = 16;
    localparam int DEPTH_BITS   = 8;
    localparam int IDX_BITS     = 5;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_LOCK   = 2'd1,
        OP_UNLOCK = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BLOCKED   = 3'd1,
        ST_NOT_OWNER = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_WAIT_FULL = 3'd4,
        ST_DEPTH_OVF = 3'd5
    } t_status;

    typedef struct packed {
        t_status                 status;
        logic [IDX_BITS-1:0]     idx;
        logic [DEPTH_BITS-1:0]   depth;
        logic                    hv;
        logic [TASK_ID_BITS-1:0] ht;
    } t_result;

endpackage

### rtl/core/rme_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module rme_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/recursive_mutex_engine_top.sv
// Recursive mutex engine, top level. Depends on rme_pkg, rme_ram and
// assert_macros.svh.
//
// Pool of NUM_MUTEXES recursive mutexes, each with an owner, a lock depth
// and a FIFO wait list of up to WAIT_DEPTH tasks. Requests are create,
// lock and unlock; each request returns exactly one result. Per-mutex
// state sits in a small RAM (one word per mutex) and the wait lists in a
// second RAM of NUM_MUTEXES*WAIT_DEPTH task ids. The mutex word is read at
// the accepting edge, evaluated and written back in S_EVAL, and the result
// is then registered as pending and moves into the output register, which
// drives o_valid. A new request is taken only once the engine is back in
// S_IDLE with no result pending. An unlock that hands the mutex to a
// waiter also passes through S_HAND, which performs the dependent
// read of the wait-list head from the slot RAM. One finished result may
// wait in the output register while the next request is taken in; if the
// register is still held by a stalled consumer when a further result is
// ready, that result waits internally and the input stays stalled until
// the register frees. The mutex words carry per-entry valid flops cleared
// by reset, so no clearing pass is needed; wait-list slots are only read
// once filled and have no reset.
`include "assert_macros.svh"

module recursive_mutex_engine_top
    import rme_pkg::*;
#(
    parameter int NUM_MUTEXES = 32,
    parameter int WAIT_DEPTH  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_opcode,
    input  logic [IDX_BITS-1:0]     i_mutex_index,
    input  logic [TASK_ID_BITS-1:0] i_task_id,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_status,
    output logic [IDX_BITS-1:0]     o_result_index,
    output logic [DEPTH_BITS-1:0]   o_lock_depth,
    output logic                    o_handoff_valid,
    output logic [TASK_ID_BITS-1:0] o_handoff_task
);

    localparam int AW   = $clog2(NUM_MUTEXES);        // mutex word address
    localparam int CW   = $clog2(WAIT_DEPTH + 1);     // waiter count
    localparam int HW   = $clog2(WAIT_DEPTH);         // waiter head
    localparam int SD   = NUM_MUTEXES * WAIT_DEPTH;   // slot RAM depth
    localparam int SAW  = $clog2(SD);
    localparam int ALW  = $clog2(NUM_MUTEXES + 1);    // allocation counter
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    typedef struct packed {
        logic                    own;
        logic [TASK_ID_BITS-1:0] owner;
        logic [DEPTH_BITS-1:0]   depth;
        logic [CW-1:0]           cnt;
        logic [HW-1:0]           head;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_HAND = 3'b100
    } t_state;

    // ---------------------------------------------------------------
    // Control and request registers
    // ---------------------------------------------------------------
    t_state                  r_state, n_state;
    logic [ALW-1:0]          r_alloc, n_alloc;
    logic [NUM_MUTEXES-1:0]  r_ent_vld;
    logic                    r_pend, n_pend;
    t_result                 r_res, n_res;

    logic [1:0]              r_op;
    logic [IDX_BITS-1:0]     r_idx;
    logic [TASK_ID_BITS-1:0] r_task;
    logic                    r_hit;      // mutex word written since reset
    t_entry                  r_hold;     // word awaiting the new owner id

    logic                    r_out_valid;
    t_result                 r_out;

    logic                    in_acc;
    logic                    move;
    logic [31:0]             in_idx_ext;
    logic [AW-1:0]           in_addr;
    logic [31:0]             idx_ext;
    logic [AW-1:0]           m_addr;

    // RAM ports
    logic                    st_we, st_re;
    logic [AW-1:0]           st_waddr;
    t_entry                  st_wdata;
    logic [EW-1:0]           st_rdata;
    logic                    sl_we, sl_re;
    logic [SAW-1:0]          sl_waddr, sl_raddr;
    logic [TASK_ID_BITS-1:0] sl_rdata;

    // evaluation helpers
    t_entry                  cur;
    t_entry                  hold_nx;
    logic                    is_owner;
    logic                    in_range;
    logic [SAW-1:0]          slot_base;
    logic [CW:0]             pos_sum;
    logic [HW-1:0]           tail_pos;
    logic [HW:0]             head_inc;
    logic [HW-1:0]           head_nx;
    logic [DEPTH_BITS-1:0]   depth_dec;

    // Busy while a request is in flight or a result still sits internally.
    assign o_stall = !((r_state == S_IDLE) && !r_pend);
    assign in_acc  = i_valid && !o_stall;
    assign move    = r_pend && (!r_out_valid || !i_stall);

    assign in_idx_ext = 32'(i_mutex_index);
    assign in_addr    = in_idx_ext[AW-1:0];
    assign idx_ext    = 32'(r_idx);
    assign m_addr     = idx_ext[AW-1:0];

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    assign st_re = in_acc;

    rme_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_MUTEXES)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (in_addr),
        .o_rdata (st_rdata)
    );

    rme_ram #(
        .WIDTH (TASK_ID_BITS),
        .DEPTH (SD)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (sl_we),
        .i_waddr (sl_waddr),
        .i_wdata (r_task),
        .i_re    (sl_re),
        .i_raddr (sl_raddr),
        .o_rdata (sl_rdata)
    );

    // ---------------------------------------------------------------
    // Evaluate the request against the mutex word
    // ---------------------------------------------------------------
    always_comb begin
        // A word never written since reset reads as unowned and empty.
        cur       = r_hit ? t_entry'(st_rdata) : '0;
        is_owner  = cur.own && (cur.owner == r_task);
        in_range  = idx_ext < 32'(NUM_MUTEXES);
        slot_base = SAW'(m_addr) * SAW'(WAIT_DEPTH);

        // Tail of the circular list; head + count stays below twice the depth.
        pos_sum  = (CW+1)'(cur.head) + (CW+1)'(cur.cnt);
        tail_pos = (pos_sum >= (CW+1)'(WAIT_DEPTH)) ?
                   HW'(pos_sum - (CW+1)'(WAIT_DEPTH)) : HW'(pos_sum);
        head_inc = (HW+1)'(cur.head) + (HW+1)'(1);
        head_nx  = (head_inc == (HW+1)'(WAIT_DEPTH)) ? '0 : HW'(head_inc);
        depth_dec = (cur.depth != '0) ? cur.depth - DEPTH_BITS'(1) : cur.depth;

        n_state  = r_state;
        n_alloc  = r_alloc;
        n_pend   = move ? 1'b0 : r_pend;
        n_res    = r_res;
        hold_nx  = r_hold;
        st_we    = 1'b0;
        st_waddr = m_addr;
        st_wdata = cur;
        sl_we    = 1'b0;
        sl_waddr = slot_base + SAW'(tail_pos);
        sl_re    = 1'b0;
        sl_raddr = slot_base + SAW'(cur.head);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                n_state   = S_IDLE;
                n_pend    = 1'b1;
                n_res.idx = r_idx;
                n_res.hv  = 1'b0;
                n_res.ht  = '0;
                priority if (r_op == OP_CREATE) begin
                    n_res.depth = '0;
                    if (r_alloc >= ALW'(NUM_MUTEXES)) begin
                        n_res.status = ST_EXHAUSTED;
                        n_res.idx    = '0;
                    end else begin
                        n_res.status = ST_OK;
                        n_res.idx    = IDX_BITS'(r_alloc);
                        st_we        = 1'b1;
                        st_waddr     = AW'(r_alloc);
                        st_wdata     = '0;
                        n_alloc      = r_alloc + ALW'(1);
                    end
                end else if (!in_range) begin
                    n_res.status = ST_NOT_OWNER;
                    n_res.depth  = '0;
                end else if (r_op == OP_LOCK) begin
                    priority if (is_owner) begin
                        if (cur.depth >= DEPTH_MAX) begin
                            n_res.status = ST_DEPTH_OVF;
                            n_res.depth  = cur.depth;
                        end else begin
                            st_we          = 1'b1;
                            st_wdata.depth = cur.depth + DEPTH_BITS'(1);
                            n_res.status   = ST_OK;
                            n_res.depth    = cur.depth + DEPTH_BITS'(1);
                        end
                    end else if (!cur.own) begin
                        st_we          = 1'b1;
                        st_wdata.own   = 1'b1;
                        st_wdata.owner = r_task;
                        st_wdata.depth = DEPTH_BITS'(1);
                        n_res.status   = ST_OK;
                        n_res.depth    = DEPTH_BITS'(1);
                    end else if (cur.cnt >= CW'(WAIT_DEPTH)) begin
                        n_res.status = ST_WAIT_FULL;
                        n_res.depth  = cur.depth;
                    end else begin
                        sl_we        = 1'b1;
                        st_we        = 1'b1;
                        st_wdata.cnt = cur.cnt + CW'(1);
                        n_res.status = ST_BLOCKED;
                        n_res.depth  = cur.depth;
                    end
                end else if ((r_op == OP_UNLOCK) && is_owner) begin
                    n_res.status = ST_OK;
                    priority if (depth_dec != '0) begin
                        st_we          = 1'b1;
                        st_wdata.depth = depth_dec;
                        n_res.depth    = depth_dec;
                    end else if (cur.cnt != '0) begin
                        // handoff: owner id comes from the slot RAM next cycle
                        sl_re         = 1'b1;
                        n_state       = S_HAND;
                        n_pend        = 1'b0;
                        hold_nx       = cur;
                        hold_nx.depth = DEPTH_BITS'(1);
                        hold_nx.cnt   = cur.cnt - CW'(1);
                        hold_nx.head  = head_nx;
                    end else begin
                        st_we          = 1'b1;
                        st_wdata.own   = 1'b0;
                        st_wdata.owner = '0;
                        st_wdata.depth = '0;
                        n_res.depth    = '0;
                    end
                end else begin
                    n_res.status = ST_NOT_OWNER;
                    n_res.depth  = cur.depth;
                end
            end

            S_HAND: begin
                n_state        = S_IDLE;
                n_pend         = 1'b1;
                st_we          = 1'b1;
                st_wdata       = r_hold;
                st_wdata.owner = sl_rdata;
                n_res.status   = ST_OK;
                n_res.idx      = r_idx;
                n_res.depth    = DEPTH_BITS'(1);
                n_res.hv       = 1'b1;
                n_res.ht       = sl_rdata;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alloc     <= '0;
            r_ent_vld   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_alloc <= n_alloc;
            r_pend  <= n_pend;
            if (st_we) begin
                r_ent_vld[st_waddr] <= 1'b1;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_hold <= hold_nx;
        if (in_acc) begin
            r_op   <= i_opcode;
            r_idx  <= i_mutex_index;
            r_task <= i_task_id;
            r_hit  <= r_ent_vld[in_addr];
        end
        if (move) begin
            r_out <= r_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_result_index  = r_out.idx;
    assign o_lock_depth    = r_out.depth;
    assign o_handoff_valid = r_out.hv;
    assign o_handoff_task  = r_out.ht;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `MTX_ASSERT_RST(a_handoff_shape, i_clk, i_rst_n,
        (o_valid && o_handoff_valid) |-> (o_status == ST_OK && o_lock_depth == DEPTH_BITS'(1)),
        "handoff result without ok status at depth one")
    `MTX_ASSERT_RST(a_no_task_without_handoff, i_clk, i_rst_n,
        (o_valid && !o_handoff_valid) |-> (o_handoff_task == '0),
        "handoff task set on a result without handoff")
    `MTX_ASSERT_RST(a_pend_free_in_flight, i_clk, i_rst_n,
        (r_state != S_IDLE) |-> !r_pend,
        "result would overwrite an undelivered one")
    `MTX_ASSERT_RST(a_hand_after_eval, i_clk, i_rst_n,
        (r_state == S_HAND) |-> ($past(r_state) == S_EVAL),
        "handoff cycle not preceded by evaluation")
    `MTX_ASSERT(a_alloc_bound, i_clk,
        (!i_rst_n) || (r_alloc <= ALW'(NUM_MUTEXES)),
        "allocation count beyond pool size")

endmodule
